// ===== design/irm_pkg.sv =====
package irm_pkg;

  localparam int DATA_WIDTH_DEF = 64;
  localparam int FIELD_W = 64;
  localparam int MODE_W = 3;
  localparam int STATUS_W = 2;

  localparam logic [MODE_W-1:0] RM_HALF_AWAY = 3'd0;
  localparam logic [MODE_W-1:0] RM_HALF_EVEN = 3'd1;
  localparam logic [MODE_W-1:0] RM_TRUNC     = 3'd2;
  localparam logic [MODE_W-1:0] RM_HALF_DOWN = 3'd3;
  localparam logic [MODE_W-1:0] RM_FLOOR     = 3'd4;
  localparam logic [MODE_W-1:0] RM_CEIL      = 3'd5;
  localparam logic [MODE_W-1:0] RM_HALF_CEIL = 3'd6;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF  = 2'd2;

endpackage

// ===== design/integer_round_to_multiple_core.sv =====
// integer round-to-multiple unit
// input channel in_*: in_tdata carries value and scale, in_tuser the rounding mode;
// an item is a transfer when in_tvalid and in_tready are both high
// output channel out_*: out_tdata carries the rounded value (sign extended to 64
// bits), out_tuser the status (ok, zero scale, overflow)
// only the low DATA_WIDTH bits of value and scale are used
// the remainder comes from a restoring divider with one quotient bit per stage,
// so the pipeline is DATA_WIDTH + 3 register stages deep: the input register,
// the DATA_WIDTH divider stages, the rounding decision register and the output register
// throughput is one item per cycle while the output is not stalled
// the whole pipeline advances together: while the output holds a result that
// is not taken, in_tready is low and every stage holds its item
// reset clears all valid bits; data registers are not reset
module integer_round_to_multiple_core #(
  parameter int DATA_WIDTH = irm_pkg::DATA_WIDTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // value[63:0], scale[127:64]
  input  logic [2:0]   in_tuser,   // mode[2:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // rounded[63:0]
  output logic [1:0]   out_tuser   // status[1:0]
);

  localparam int W = DATA_WIDTH;

  logic adv;

  logic             vld_r  [0:W];
  logic [W-1:0]     n_r    [0:W];
  logic [W-1:0]     sc_r   [0:W];
  logic [W-1:0]     rem_r  [0:W];
  logic             vneg_r [0:W];
  logic             zero_r [0:W];
  logic [2:0]       mode_r [0:W];
  logic [W-1:0]     vraw_r [0:W];
  logic             q0_r;

  logic [W-1:0] v_in, s_in;
  assign v_in = in_tdata[W-1:0];
  assign s_in = in_tdata[64+W-1:64];

  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      n_r[0]    <= v_in[W-1] ? (~v_in + 1'b1) : v_in;
      sc_r[0]   <= s_in[W-1] ? (~s_in + 1'b1) : s_in;
      vneg_r[0] <= v_in[W-1];
      zero_r[0] <= (s_in == '0);
      mode_r[0] <= in_tuser;
      vraw_r[0] <= v_in;
      rem_r[0]  <= '0;
    end
  end

  // restoring divider, one quotient bit per stage
  genvar i;
  generate
    for (i = 1; i <= W; i++) begin : g_div
      logic [W:0] trial;
      logic       ge;
      assign trial = {rem_r[i-1], n_r[i-1][W-i]};
      assign ge = (trial >= {1'b0, sc_r[i-1]});

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[i] <= 1'b0;
        end else if (adv) begin
          vld_r[i] <= vld_r[i-1];
        end
      end

      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[i]  <= ge ? W'(trial - {1'b0, sc_r[i-1]}) : trial[W-1:0];
          n_r[i]    <= n_r[i-1];
          sc_r[i]   <= sc_r[i-1];
          vneg_r[i] <= vneg_r[i-1];
          zero_r[i] <= zero_r[i-1];
          mode_r[i] <= mode_r[i-1];
          vraw_r[i] <= vraw_r[i-1];
        end
      end

      if (i == W) begin : g_last
        always_ff @(posedge clk) begin
          if (adv) begin
            q0_r <= ge;
          end
        end
      end
    end
  endgenerate

  // rounding decision stage
  logic [W-1:0] r_c, s_c, low_c;
  logic [W:0]   high_c;
  logic         up_c;

  assign r_c    = rem_r[W];
  assign s_c    = sc_r[W] - r_c;
  assign low_c  = n_r[W] - r_c;
  assign high_c = {1'b0, n_r[W]} + {1'b0, s_c};

  always_comb begin
    up_c = 1'b0;
    case (mode_r[W])
      irm_pkg::RM_TRUNC: up_c = 1'b0;
      irm_pkg::RM_FLOOR: up_c = vneg_r[W];
      irm_pkg::RM_CEIL:  up_c = !vneg_r[W];
      default: begin
        if (r_c < s_c) up_c = 1'b0;
        else if (r_c > s_c) up_c = 1'b1;
        else if (mode_r[W] == irm_pkg::RM_HALF_EVEN) up_c = q0_r;
        else if (mode_r[W] == irm_pkg::RM_HALF_DOWN) up_c = 1'b0;
        else if (mode_r[W] == irm_pkg::RM_HALF_CEIL) up_c = !vneg_r[W];
        else up_c = 1'b1;
      end
    endcase
  end

  logic         vld_d_r;
  logic         zero_d_r, exact_d_r, neg_d_r;
  logic [W:0]   mag_d_r;
  logic [W-1:0] vraw_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_d_r <= 1'b0;
    end else if (adv) begin
      vld_d_r <= vld_r[W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero_d_r  <= zero_r[W];
      exact_d_r <= (r_c == '0);
      neg_d_r   <= vneg_r[W];
      mag_d_r   <= up_c ? high_c : {1'b0, low_c};
      vraw_d_r  <= vraw_r[W];
    end
  end

  // compose stage, output register
  localparam logic [W:0] LIM_NEG = (W+1)'(1) << (W-1);
  localparam logic [W:0] LIM_POS = LIM_NEG - (W+1)'(1);

  logic         ovf_c;
  logic [W-1:0] res_c;
  logic         out_valid_r;
  logic [63:0]  rounded_r;
  logic [1:0]   status_r;

  assign ovf_c = mag_d_r > (neg_d_r ? LIM_NEG : LIM_POS);
  assign res_c = neg_d_r ? (~mag_d_r[W-1:0] + 1'b1) : mag_d_r[W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_d_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (zero_d_r) begin
        rounded_r <= '0;
        status_r  <= irm_pkg::ST_ZERO;
      end else if (exact_d_r) begin
        rounded_r <= 64'($signed(vraw_d_r));
        status_r  <= irm_pkg::ST_OK;
      end else if (ovf_c) begin
        rounded_r <= '0;
        status_r  <= irm_pkg::ST_OVF;
      end else begin
        rounded_r <= 64'($signed(res_c));
        status_r  <= irm_pkg::ST_OK;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = rounded_r;
  assign out_tuser  = status_r;

endmodule

// ===== design/irm_checker.sv =====
module irm_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic [1:0]   out_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken while output stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == irm_pkg::ST_ZERO || out_tuser == irm_pkg::ST_OVF)
      |-> out_tdata == 64'd0)
    else $error("error status with nonzero result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser != 2'd3)
    else $error("undefined status code");

endmodule

bind integer_round_to_multiple_core irm_checker u_irm_checker (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser)
);
